### design/handle_slot_allocator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the handle slot allocator
// Shared wrappers for concurrent checks clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HANDLE_SLOT_ALLOCATOR_MACROS_SVH
`define HANDLE_SLOT_ALLOCATOR_MACROS_SVH

// A condition that must hold in the same cycle as its trigger.
`define HSA_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("handle slot allocator check failed");

// A condition that must hold in the cycle after its trigger.
`define HSA_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("handle slot allocator check failed");

`endif

### design/hsa_pkg.sv
// ----------------------------------------------------------------------------
// hsa_pkg
// Sizes, command and status codes and shared structs of the handle allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hsa_pkg;

  localparam int SLOTS  = 256;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int HDL_W  = 16;
  localparam int OBJ_W  = 32;
  localparam int ACC_W  = 8;
  localparam int GEN_W  = 16;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             used;
    logic [GEN_W-1:0] generation;
    logic [ACC_W-1:0] access;
    logic [OBJ_W-1:0] object;
  } slot_data_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
  } stk_req_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_data_t       wdata;
  } slot_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [HDL_W-1:0] handle;
    logic [OBJ_W-1:0] object;
    logic [ACC_W-1:0] access;
    logic [GEN_W-1:0] generation;
    logic             release_obj;
  } result_t;

endpackage

### design/hsa_ram.sv
// ----------------------------------------------------------------------------
// hsa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // The read data holds until the next read, so a stalled result stays put.
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/hsa_ctrl.sv
// ----------------------------------------------------------------------------
// hsa_ctrl
// Command sequencer: free stack pop and push, slot table read-modify-write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hsa_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [1:0]              in_cmd,
  input  logic [hsa_pkg::HDL_W-1:0] in_handle,
  input  logic [hsa_pkg::OBJ_W-1:0] in_object,
  input  logic [hsa_pkg::ACC_W-1:0] in_access,
  output hsa_pkg::stk_req_t       stk_req,
  input  logic [hsa_pkg::IDX_W-1:0] stk_rdata,
  output hsa_pkg::slot_req_t      slot_req,
  input  hsa_pkg::slot_data_t     slot_rdata,
  output logic                    res_valid,
  input  logic                    res_ready,
  output hsa_pkg::result_t        res
);

  import hsa_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_POP, S_FIN} state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [OBJ_W-1:0] obj_r, obj_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [IDX_W-1:0] pop_addr_r, pop_addr_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             live_r, live_nxt;
  logic [CNT_W-1:0] free_top_r, free_top_nxt;
  logic [CNT_W-1:0] low_r, low_nxt;

  logic [CNT_W-1:0] top_m1;
  logic [CNT_W-1:0] seen_lim;
  logic [IDX_W-1:0] h_idx;
  logic             h_bad;
  logic             stk_written;
  logic [IDX_W-1:0] pop_idx;
  logic             slot_used;
  logic [GEN_W-1:0] cur_gen;
  logic [GEN_W-1:0] new_gen;

  assign in_tready = (state_r == S_IDLE);
  assign res_valid = (state_r == S_FIN);

  // low_r is the lowest value the stack top has ever reached. Stack entries at
  // or above it have been written by a push; slots below SLOTS - low_r have
  // been allocated at least once. Everything else still holds its reset value.
  assign top_m1      = free_top_r - CNT_W'(1);
  assign seen_lim    = CNT_W'(SLOTS) - low_r;
  assign h_idx       = in_handle[IDX_W-1:0];
  assign h_bad       = ({1'b0, in_handle} >= (HDL_W + 1)'(SLOTS));
  assign stk_written = (CNT_W'(pop_addr_r) >= low_r);
  assign pop_idx     = stk_written ? stk_rdata : (IDX_W'(SLOTS - 1) - pop_addr_r);
  assign slot_used   = live_r && slot_rdata.used;
  assign cur_gen     = live_r ? slot_rdata.generation : '0;
  assign new_gen     = cur_gen + GEN_W'(1);

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    obj_nxt      = obj_r;
    acc_nxt      = acc_r;
    err_nxt      = err_r;
    pop_addr_nxt = pop_addr_r;
    idx_nxt      = idx_r;
    live_nxt     = live_r;
    free_top_nxt = free_top_r;
    low_nxt      = low_r;
    stk_req      = '0;
    slot_req     = '0;
    res          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          obj_nxt   = in_object;
          acc_nxt   = in_access;
          idx_nxt   = h_idx;
          live_nxt  = (CNT_W'(h_idx) < seen_lim);
          err_nxt   = ST_OK;
          state_nxt = S_FIN;
          unique case (in_cmd)
            CMD_ALLOC: begin
              if (free_top_r == '0) begin
                err_nxt = ST_FULL;
              end else begin
                stk_req.re    = 1'b1;
                stk_req.raddr = top_m1[IDX_W-1:0];
                pop_addr_nxt  = top_m1[IDX_W-1:0];
                state_nxt     = S_POP;
              end
            end
            CMD_FREE, CMD_LOOKUP: begin
              if (h_bad) begin
                err_nxt = ST_INVAL;
              end else begin
                slot_req.re    = 1'b1;
                slot_req.raddr = h_idx;
              end
            end
            default: begin
              err_nxt = ST_INVAL;
            end
          endcase
        end
      end

      S_POP: begin
        // A slot taken from a stack entry that was never pushed is fresh.
        idx_nxt        = pop_idx;
        live_nxt       = stk_written;
        slot_req.re    = 1'b1;
        slot_req.raddr = pop_idx;
        state_nxt      = S_FIN;
      end

      S_FIN: begin
        res.status = err_r;
        if (err_r == ST_OK) begin
          unique case (cmd_r)
            CMD_ALLOC: begin
              if (slot_used) begin
                res.status = ST_FULL;
              end else begin
                res.handle     = HDL_W'(idx_r);
                res.generation = new_gen;
              end
            end
            CMD_LOOKUP: begin
              if (!slot_used) begin
                res.status = ST_INVAL;
              end else begin
                res.object     = slot_rdata.object;
                res.access     = slot_rdata.access;
                res.generation = cur_gen;
              end
            end
            default: begin
              if (!slot_used || free_top_r >= CNT_W'(SLOTS)) begin
                res.status = ST_INVAL;
              end else begin
                res.object      = slot_rdata.object;
                res.release_obj = 1'b1;
              end
            end
          endcase
        end
        if (res_ready) begin
          state_nxt = S_IDLE;
          if (res.status == ST_OK && cmd_r == CMD_ALLOC) begin
            slot_req.we               = 1'b1;
            slot_req.waddr            = idx_r;
            slot_req.wdata.used       = 1'b1;
            slot_req.wdata.object     = obj_r;
            slot_req.wdata.access     = acc_r;
            slot_req.wdata.generation = new_gen;
            free_top_nxt              = top_m1;
            if (top_m1 < low_r) begin
              low_nxt = top_m1;
            end
          end
          if (res.release_obj) begin
            stk_req.we                = 1'b1;
            stk_req.waddr             = free_top_r[IDX_W-1:0];
            stk_req.wdata             = idx_r;
            slot_req.we               = 1'b1;
            slot_req.waddr            = idx_r;
            slot_req.wdata.generation = cur_gen;
            free_top_nxt              = free_top_r + CNT_W'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_top_r <= CNT_W'(SLOTS);
      low_r      <= CNT_W'(SLOTS);
    end else begin
      state_r    <= state_nxt;
      free_top_r <= free_top_nxt;
      low_r      <= low_nxt;
    end
    cmd_r      <= cmd_nxt;
    obj_r      <= obj_nxt;
    acc_r      <= acc_nxt;
    err_r      <= err_nxt;
    pop_addr_r <= pop_addr_nxt;
    idx_r      <= idx_nxt;
    live_r     <= live_nxt;
  end

endmodule

### design/handle_slot_allocator.sv
// ----------------------------------------------------------------------------
// handle_slot_allocator
// Fixed-size handle table with a free-index stack, stream in and stream out.
// ----------------------------------------------------------------------------
// One item is worked on at a time. An allocate holds the block through the
// accepting cycle, a read of the free stack memory, then a read of the slot
// memory at the popped index, while free, lookup and rejected items skip the
// stack read and do one slot memory read, skipped when the item is rejected at
// once. The result enters the output register at the end of the last of these
// steps, once that register can take it, and the next item can be accepted in
// the following cycle. The output register lets the next item be accepted
// while a result still waits. After reset the block is ready at once: a
// low-water mark of the free stack tells which stack entries and slots have
// ever been written, so neither memory needs a clearing pass. Handles are
// plain slot indices; the first allocation after reset yields slot 0.
`timescale 1ns / 1ps

module handle_slot_allocator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // in_tdata, lowest bit up: handle_in[15:0], object_ref[31:0], access_in[7:0]
  input  logic [55:0] in_tdata,
  // in_tuser: cmd[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata, lowest bit up: handle_out[15:0], object_out[31:0],
  // access_out[7:0], generation_out[15:0]
  output logic [71:0] out_tdata,
  // out_tuser, lowest bit up: status[1:0], release_object
  output logic [2:0]  out_tuser
);

  import hsa_pkg::*;

  `include "handle_slot_allocator_macros.svh"

  stk_req_t         stk_req;
  slot_req_t        slot_req;
  logic [IDX_W-1:0] stk_rdata;
  slot_data_t       slot_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;

  logic             out_valid_r;
  result_t          out_res_r;

  hsa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

  hsa_ram #(
    .WIDTH ($bits(slot_data_t)),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (slot_req.we),
    .waddr (slot_req.waddr),
    .wdata (slot_req.wdata),
    .re    (slot_req.re),
    .raddr (slot_req.raddr),
    .rdata (slot_rdata)
  );

  hsa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_handle  (in_tdata[15:0]),
    .in_object  (in_tdata[47:16]),
    .in_access  (in_tdata[55:48]),
    .stk_req    (stk_req),
    .stk_rdata  (stk_rdata),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.generation, out_res_r.access,
                       out_res_r.object, out_res_r.handle};
  assign out_tuser  = {out_res_r.release_obj, out_res_r.status};

  `HSA_ASSERT_SAME(a_release_ok, out_tvalid && out_tuser[2], out_tuser[1:0] == ST_OK)
  `HSA_ASSERT_SAME(a_full_zero, out_tvalid && out_tuser[1:0] == ST_FULL, out_tdata == '0)
  `HSA_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  `HSA_ASSERT_SAME(a_handle_range, out_tvalid && out_tuser[1:0] == ST_OK,
                   {1'b0, out_tdata[15:0]} < 17'(SLOTS))

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for handle_slot_allocator. A behavioural copy of the
// handle table predicts every result, and each result is checked on arrival.
// The stimulus covers directed corner cases, repeated reuse of one slot and
// random runs that fill, drain and mix, under random back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import hsa_pkg::*;

  // Command code with no meaning to the block; it must be rejected as invalid.
  localparam logic [1:0] CMD_BAD = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned WRAP_PAIRS = 16;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_t;

  class handle_table_model;
    logic [HDL_W-1:0] free_stack [SLOTS];
    int unsigned      free_top;
    logic [OBJ_W-1:0] slot_object [SLOTS];
    logic [ACC_W-1:0] slot_access [SLOTS];
    bit               slot_used [SLOTS];
    logic [GEN_W-1:0] slot_generation [SLOTS];
    result_t          pending_replies [$];
    int unsigned      errors, checked, n_full, n_inval, n_release;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        free_stack[i] = HDL_W'(SLOTS - 1 - i);
        slot_object[i] = '0;
        slot_access[i] = '0;
        slot_used[i] = 1'b0;
        slot_generation[i] = '0;
      end
      free_top = SLOTS;
    endfunction

    // Applies one accepted item to the table and queues the reply it causes.
    function result_t note_request(logic [1:0] cmd, logic [HDL_W-1:0] hdl,
                                   logic [OBJ_W-1:0] obj, logic [ACC_W-1:0] acc);
      result_t r;
      int unsigned idx;
      r = '0;
      r.status = ST_INVAL;
      idx = 32'(hdl);
      case (cmd)
        CMD_ALLOC: begin
          if (free_top == 0) begin
            r.status = ST_FULL;
          end else begin
            free_top--;
            idx = 32'(free_stack[free_top]);
            slot_object[idx] = obj;
            slot_access[idx] = acc;
            slot_used[idx] = 1'b1;
            slot_generation[idx] = slot_generation[idx] + 1'b1;
            r.status = ST_OK;
            r.handle = HDL_W'(idx);
            r.generation = slot_generation[idx];
          end
        end
        CMD_FREE, CMD_LOOKUP: begin
          if (idx < SLOTS && slot_used[idx]) begin
            r.status = ST_OK;
            r.object = slot_object[idx];
            if (cmd == CMD_LOOKUP) begin
              r.access = slot_access[idx];
              r.generation = slot_generation[idx];
            end else begin
              slot_object[idx] = '0;
              slot_access[idx] = '0;
              slot_used[idx] = 1'b0;
              free_stack[free_top] = HDL_W'(idx);
              free_top++;
              r.release_obj = 1'b1;
              n_release++;
            end
          end
        end
        default: ;
      endcase
      if (r.status == ST_FULL) n_full++;
      if (r.status == ST_INVAL) n_inval++;
      pending_replies.push_back(r);
      return r;
    endfunction

    // Returns a random slot that is (or is not) occupied, or -1 if none is.
    function int pick_slot(bit occupied);
      int unsigned start;
      int unsigned k;
      start = $urandom_range(SLOTS - 1);
      for (int i = 0; i < SLOTS; i++) begin
        k = (start + i) % SLOTS;
        if (slot_used[k] == occupied) return k;
      end
      return -1;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_reply(logic [71:0] d, logic [2:0] u);
      result_t want;
      if (pending_replies.size() == 0) begin
        $error("result with no item outstanding: tdata %h, tuser %h", d, u);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      compare_field("status", 32'(want.status), 32'(u[1:0]));
      compare_field("handle_out", 32'(want.handle), 32'(d[15:0]));
      compare_field("object_out", want.object, d[47:16]);
      compare_field("access_out", 32'(want.access), 32'(d[55:48]));
      compare_field("generation_out", 32'(want.generation), 32'(d[71:56]));
      compare_field("release_object", 32'(want.release_obj), 32'(u[2]));
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [2:0]  out_tuser;

  handle_table_model tbl;
  bit          steady = 1'b0;
  int unsigned burst_left = 0;
  int unsigned random_sent = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  handle_slot_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("handle_slot_allocator: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tbl.check_reply(out_tdata, out_tuser);
  end

  // Bursts of back-to-back items separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (steady) return;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [HDL_W-1:0] hdl,
                       input logic [OBJ_W-1:0] obj, input logic [ACC_W-1:0] acc,
                       output result_t r);
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {acc, obj, hdl};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = tbl.note_request(cmd, hdl, obj, acc);
    items_sent++;
    pace();
  endtask

  // Mostly well-formed traffic on live handles, with some rejected requests.
  task automatic random_item(input mix_t mix);
    int unsigned roll, a_lim, f_lim, l_lim;
    int          slot;
    logic [1:0]  cmd;
    logic [HDL_W-1:0] hdl;
    result_t     r;
    case (mix)
      MIX_FILL:  begin a_lim = 92; f_lim = 95; l_lim = 97; end
      MIX_DRAIN: begin a_lim = 10; f_lim = 75; l_lim = 90; end
      default:   begin a_lim = 35; f_lim = 60; l_lim = 85; end
    endcase
    roll = $urandom_range(99);
    cmd = CMD_ALLOC;
    hdl = HDL_W'($urandom());
    if (roll < a_lim) begin
      cmd = CMD_ALLOC;
    end else if (roll < l_lim) begin
      cmd = (roll < f_lim) ? CMD_FREE : CMD_LOOKUP;
      slot = tbl.pick_slot(1'b1);
      if (slot >= 0) hdl = HDL_W'(slot);
      else cmd = CMD_ALLOC;
    end else begin
      case ($urandom_range(2))
        0:       cmd = CMD_BAD;
        1:       cmd = CMD_FREE;
        default: cmd = CMD_LOOKUP;
      endcase
      slot = tbl.pick_slot(1'b0);
      if ($urandom_range(1) == 1 && slot >= 0) hdl = HDL_W'(slot);
      else hdl = HDL_W'($urandom_range(16'hFFFF, SLOTS));
    end
    issue(cmd, hdl, OBJ_W'($urandom()), ACC_W'($urandom()), r);
  endtask

  initial begin : receiver
    int unsigned span, pct;
    bit held;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (!held && random_sent >= 60) begin
        // Long hold-off so that the block backs up and stalls its input.
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(4, 64);
        case ($urandom_range(2))
          0:       pct = 100;
          1:       pct = 60;
          default: pct = 20;
        endcase
        repeat (span) begin
          out_tready <= ($urandom_range(99) < pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    result_t r;
    mix_t    mix;
    tbl = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases on an empty table.
    issue(CMD_LOOKUP, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_ALLOC, 16'h0000, 32'h0000_0000, 8'h00, r);
    issue(CMD_ALLOC, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, r);
    issue(CMD_LOOKUP, 16'd0, 32'hFFFF_FFFF, 8'hFF, r);
    issue(CMD_LOOKUP, 16'd1, 32'h0, 8'h00, r);
    issue(CMD_LOOKUP, HDL_W'(SLOTS), 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, r);
    issue(CMD_LOOKUP, 16'hFFFF, 32'h0, 8'h00, r);
    issue(CMD_LOOKUP, HDL_W'(SLOTS - 1), 32'h0, 8'h00, r);
    issue(CMD_BAD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, r);
    issue(CMD_BAD, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_LOOKUP, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_ALLOC, 16'h5A5A, 32'hA5A5_5A5A, 8'h5A, r);
    issue(CMD_LOOKUP, 16'd0, 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'd1, 32'h0, 8'h00, r);
    issue(CMD_FREE, 16'd0, 32'h0, 8'h00, r);

    // Reusing one slot over and over steps its generation up each time.
    steady = 1'b1;
    for (int n = 0; n < WRAP_PAIRS; n++) begin
      issue(CMD_ALLOC, HDL_W'($urandom()), $urandom(), ACC_W'($urandom()), r);
      if (r.status == ST_OK) begin
        issue(CMD_FREE, r.handle, $urandom(), ACC_W'($urandom()), r);
      end
    end
    steady = 1'b0;

    // Blocks that fill the table past full, drain it, then mix.
    for (int blk = 0; blk < 14; blk++) begin
      mix = (blk < 9) ? MIX_FILL : (blk < 12) ? MIX_DRAIN : MIX_MIXED;
      repeat (36) begin
        random_item(mix);
        random_sent++;
      end
    end

    in_tvalid <= 1'b0;
    while (tbl.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items (%0d random), checked %0d results in %0d cycles.",
             items_sent, random_sent, tbl.checked, cycle_count);
    $display("Seen: %0d table-full, %0d invalid-handle and %0d release results.",
             tbl.n_full, tbl.n_inval, tbl.n_release);
    if (tbl.errors == 0) begin
      $display("handle_slot_allocator: match");
    end else begin
      $display("handle_slot_allocator: mismatch");
    end
    $finish;
  end

endmodule

### handle_slot_allocator.f
+incdir+design
design/hsa_pkg.sv
design/hsa_ram.sv
design/hsa_ctrl.sv
design/handle_slot_allocator.sv
tb/tb.sv
